// ===== rtl/lbp_pkg.sv =====
// shared types and constants for the lsb-first bit packer
package lbp_pkg;

  // width of the integer taken by an integer append
  localparam int INT_WIDTH = 64;

  // widths of the bit accumulator and its fill count
  localparam int ACC_W = 16;
  localparam int CNT_W = 5;

  // input operation codes
  typedef enum logic [1:0] {
    OP_BIT   = 2'd0,
    OP_BYTE  = 2'd1,
    OP_INT   = 2'd2,
    OP_FLUSH = 2'd3
  } op_t;

  // sequencer states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_t;

  // commands to the shared shift unit
  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_DROP   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_kind_t;

  // one command: append seg (len bits, lsb first), drop a byte, or clear
  typedef struct packed {
    cmd_kind_t  kind;
    logic [8:0] seg;
    logic [3:0] len;
  } unit_cmd_t;

endpackage

// ===== rtl/lsb_first_bit_packer_with_varint_unit.sv =====
// top level of the lsb-first bit packer with variable-length integer append
// One item is taken at a time; in_ready is high only while the block is idle.
// A sequencer feeds one segment per cycle while no full byte is waiting (a bit,
// a byte, or a 9-bit integer group of 0 marker plus data byte, then the
// closing 1 marker) into a shared shift unit holding a 16-bit accumulator,
// and every full byte goes out as its own beat, one per cycle while
// out_ready is high, the shift unit taking either one append or one byte
// drop per cycle.
module lsb_first_bit_packer_with_varint_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [63:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [3:0]  out_valid_bits,
  output logic        out_last_of_run
);

  lbp_pkg::unit_cmd_t          cmd;
  logic [lbp_pkg::ACC_W-1:0]   acc;
  logic [lbp_pkg::CNT_W-1:0]   cnt;

  // control sequencer
  lbp_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_valid_bits  (out_valid_bits),
    .out_last_of_run (out_last_of_run),
    .acc             (acc),
    .cnt             (cnt),
    .cmd             (cmd)
  );

  // shared shift unit and accumulator
  lbp_shift_unit u_shift (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .acc   (acc),
    .cnt   (cnt)
  );

endmodule

// ===== rtl/lbp_shift_unit.sv =====
// shared shift unit: holds the bit accumulator, appends segments and drops bytes
module lbp_shift_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lbp_pkg::unit_cmd_t             cmd,
  output logic [lbp_pkg::ACC_W-1:0]      acc,
  output logic [lbp_pkg::CNT_W-1:0]      cnt
);

  logic [lbp_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic [lbp_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  // next accumulator contents
  always_comb begin
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    unique case (cmd.kind)
      lbp_pkg::CMD_NONE: begin
      end
      lbp_pkg::CMD_APPEND: begin
        acc_nxt = acc_r | ({7'd0, cmd.seg} << cnt_r[2:0]);
        cnt_nxt = cnt_r + {1'b0, cmd.len};
      end
      lbp_pkg::CMD_DROP: begin
        acc_nxt = {8'd0, acc_r[lbp_pkg::ACC_W-1:8]};
        cnt_nxt = cnt_r - 5'd8;
      end
      lbp_pkg::CMD_CLEAR: begin
        acc_nxt = '0;
        cnt_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  // accumulator registers, empty after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      cnt_r <= '0;
    end else begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign acc = acc_r;
  assign cnt = cnt_r;

endmodule

// ===== rtl/lbp_seq.sv =====
// sequencer: takes one item, feeds segments to the shift unit, hands out bytes
module lbp_seq (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_op,
  input  logic [63:0]                    in_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_byte,
  output logic [3:0]                     out_valid_bits,
  output logic                           out_last_of_run,
  input  logic [lbp_pkg::ACC_W-1:0]      acc,
  input  logic [lbp_pkg::CNT_W-1:0]      cnt,
  output lbp_pkg::unit_cmd_t             cmd
);

  lbp_pkg::state_t                 state_r, state_nxt;
  lbp_pkg::op_t                    op_r, op_nxt;
  logic [lbp_pkg::INT_WIDTH-1:0]   v_r, v_nxt;
  logic                            seg_done_r, seg_done_nxt;
  logic                            full_byte;
  logic                            flush_out;

  assign full_byte = cnt[4] | cnt[3];
  assign flush_out = (op_r == lbp_pkg::OP_FLUSH) && (cnt != '0);

  // handshake and output beat
  assign in_ready        = (state_r == lbp_pkg::ST_IDLE);
  assign out_valid       = (state_r == lbp_pkg::ST_RUN) && (full_byte || flush_out);
  assign out_byte        = acc[7:0];
  assign out_valid_bits  = full_byte ? 4'd8 : cnt[3:0];
  // a full byte is last unless more bits follow: a second held byte, another
  // integer group, or a closing marker that tops up seven leftover bits
  assign out_last_of_run = full_byte ?
                           (!cnt[4] && (seg_done_r || ((v_r == '0) && (cnt[2:0] != 3'd7)))) :
                           1'b1;

  // next state, segment generation and unit command
  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    v_nxt        = v_r;
    seg_done_nxt = seg_done_r;
    cmd.kind     = lbp_pkg::CMD_NONE;
    cmd.seg      = '0;
    cmd.len      = '0;
    unique case (state_r)
      lbp_pkg::ST_IDLE: begin
        if (in_valid) begin
          op_nxt       = lbp_pkg::op_t'(in_op);
          v_nxt        = in_value[lbp_pkg::INT_WIDTH-1:0];
          seg_done_nxt = (lbp_pkg::op_t'(in_op) == lbp_pkg::OP_FLUSH);
          state_nxt    = lbp_pkg::ST_RUN;
        end
      end
      lbp_pkg::ST_RUN: begin
        if (full_byte) begin
          // a whole byte is waiting
          if (out_ready) begin
            cmd.kind = lbp_pkg::CMD_DROP;
          end
        end else if (flush_out) begin
          // padded partial byte on flush
          if (out_ready) begin
            cmd.kind = lbp_pkg::CMD_CLEAR;
          end
        end else if (!seg_done_r) begin
          cmd.kind = lbp_pkg::CMD_APPEND;
          unique case (op_r)
            lbp_pkg::OP_BIT: begin
              cmd.seg      = {8'd0, v_r[0]};
              cmd.len      = 4'd1;
              seg_done_nxt = 1'b1;
            end
            lbp_pkg::OP_BYTE: begin
              cmd.seg      = {1'b0, v_r[7:0]};
              cmd.len      = 4'd8;
              seg_done_nxt = 1'b1;
            end
            lbp_pkg::OP_INT: begin
              if (v_r != '0) begin
                // group: 0 marker then the next low byte
                cmd.seg = {v_r[7:0], 1'b0};
                cmd.len = 4'd9;
                v_nxt   = v_r >> 8;
              end else begin
                // closing 1 marker
                cmd.seg      = 9'd1;
                cmd.len      = 4'd1;
                seg_done_nxt = 1'b1;
              end
            end
            lbp_pkg::OP_FLUSH: begin
              cmd.kind     = lbp_pkg::CMD_NONE;
              seg_done_nxt = 1'b1;
            end
            default: begin
              cmd.kind = lbp_pkg::CMD_NONE;
            end
          endcase
        end else begin
          state_nxt = lbp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lbp_pkg::ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= lbp_pkg::ST_IDLE;
      seg_done_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      seg_done_r <= seg_done_nxt;
    end
  end

  // item registers
  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    v_r  <= v_nxt;
  end

endmodule

// ===== tb/tb_lsb_first_bit_packer_with_varint_unit.sv =====
// testbench for the lsb-first bit packer with variable-length integer append
`timescale 1ns / 100ps

module tb_lsb_first_bit_packer_with_varint_unit;

  // one pending input beat; hold_for_drain waits until all packed bytes are out
  typedef struct {
    lbp_pkg::op_t op;
    logic [63:0]  value;
    bit           hold_for_drain;
  } pack_item_t;

  // one packed byte as it should leave the block
  typedef struct packed {
    logic [7:0] data;
    logic [3:0] nbits;
    logic       last;
  } packed_byte_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_valid = 1'b0;
  logic         in_ready;
  lbp_pkg::op_t in_op = lbp_pkg::OP_BIT;
  logic [63:0]  in_value = '0;
  logic         out_valid;
  logic         out_ready = 1'b0;
  logic [7:0]   out_byte;
  logic [3:0]   out_valid_bits;
  logic         out_last_of_run;

  pack_item_t   pending_items[$];
  packed_byte_t expected_bytes[$];

  // packer state as the predictor sees it
  logic [7:0]  held_bits = '0;
  logic [3:0]  held_count = '0;

  int unsigned items_in = 0;
  int unsigned mismatch_count = 0;
  int unsigned stall_left = 0;
  bit          stall_armed = 1'b1;

  lsb_first_bit_packer_with_varint_unit DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_valid_bits (out_valid_bits),
    .out_last_of_run(out_last_of_run)
  );

  always #10 clk = ~clk;

  task report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] error: %s", $time, msg);
  endtask

  task add_item(input lbp_pkg::op_t op, input logic [63:0] value, input bit hold_for_drain);
    pack_item_t it;
    it.op = op;
    it.value = value;
    it.hold_for_drain = hold_for_drain;
    pending_items.push_back(it);
  endtask

  // shift one bit into the held byte, emitting it once full
  task shift_in_bit(input logic b);
    packed_byte_t pb;
    held_bits[held_count[2:0]] = b;
    held_count = held_count + 4'd1;
    if (held_count == 4'd8) begin
      pb.data = held_bits;
      pb.nbits = 4'd8;
      pb.last = 1'b0;
      expected_bytes.push_back(pb);
      held_bits = '0;
      held_count = '0;
    end
  endtask

  // work out the packed bytes caused by one accepted input beat
  task pack_predict(input lbp_pkg::op_t op, input logic [63:0] value);
    int unsigned  first_idx;
    logic [63:0]  rest;
    logic [63:0]  int_mask;
    packed_byte_t pb;
    first_idx = expected_bytes.size();
    int_mask = (lbp_pkg::INT_WIDTH >= 64) ? '1 :
               ((64'd1 << lbp_pkg::INT_WIDTH) - 64'd1);
    case (op)
      lbp_pkg::OP_BIT: begin
        shift_in_bit(value[0]);
      end
      lbp_pkg::OP_BYTE: begin
        for (int i = 0; i < 8; i++) shift_in_bit(value[i]);
      end
      lbp_pkg::OP_INT: begin
        rest = value & int_mask;
        while (rest != 0) begin
          shift_in_bit(1'b0);
          for (int i = 0; i < 8; i++) shift_in_bit(rest[i]);
          rest = rest >> 8;
        end
        shift_in_bit(1'b1);
      end
      default: begin
        if (held_count != 0) begin
          pb.data = held_bits;
          pb.nbits = held_count;
          pb.last = 1'b0;
          expected_bytes.push_back(pb);
          held_bits = '0;
          held_count = '0;
        end
      end
    endcase
    // mark the final byte of this beat
    if (expected_bytes.size() > first_idx) begin
      pb = expected_bytes.pop_back();
      pb.last = 1'b1;
      expected_bytes.push_back(pb);
    end
  endtask

  // idle rates per phase: sender light / receiver heavy, then swapped, then none
  function automatic int unsigned sender_idle_pct();
    if (items_in < 95) return 35;
    else if (items_in < 190) return 85;
    else return 0;
  endfunction

  function automatic int unsigned receiver_idle_pct();
    if (items_in < 95) return 85;
    else if (items_in < 190) return 35;
    else return 0;
  endfunction

  // driver: offer queued beats, predict on acceptance
  always @(posedge clk) begin
    bit         busy;
    bit         offer;
    pack_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      if (in_valid && in_ready) begin
        pack_predict(in_op, in_value);
        items_in <= items_in + 1;
        busy = 1'b0;
      end
      if (!busy) begin
        offer = (pending_items.size() != 0) && ($urandom_range(99) >= sender_idle_pct());
        if (offer && pending_items[0].hold_for_drain && expected_bytes.size() != 0) begin
          offer = 1'b0;
        end
        if (offer) begin
          nxt = pending_items.pop_front();
          in_op <= nxt.op;
          in_value <= nxt.value;
        end
        in_valid <= offer;
      end
    end
  end

  // long receiver hold-off, once, while the sender keeps offering
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left <= 0;
      stall_armed <= 1'b1;
    end else if (stall_armed && items_in >= 40) begin
      stall_left <= 300;
      stall_armed <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // receiver ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= (stall_left == 0) && ($urandom_range(99) >= receiver_idle_pct());
    end
  end

  // monitor: compare each output beat with the oldest predicted byte
  always @(posedge clk) begin
    packed_byte_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected beat: byte %02h bits %0d last %0b",
                                  out_byte, out_valid_bits, out_last_of_run));
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte !== want.data) begin
          report_mismatch($sformatf("out_byte %02h, predicted %02h", out_byte, want.data));
        end
        if (out_valid_bits !== want.nbits) begin
          report_mismatch($sformatf("out_valid_bits %0d, predicted %0d",
                                    out_valid_bits, want.nbits));
        end
        if (out_last_of_run !== want.last) begin
          report_mismatch($sformatf("out_last_of_run %0b, predicted %0b",
                                    out_last_of_run, want.last));
        end
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    int unsigned sel;
    int unsigned nbytes;
    logic [63:0] v;

    // directed: field extremes, every op, flush with and without held bits
    add_item(lbp_pkg::OP_BIT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    add_item(lbp_pkg::OP_BIT, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
    add_item(lbp_pkg::OP_FLUSH, 64'h0, 1'b0);
    add_item(lbp_pkg::OP_FLUSH, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    add_item(lbp_pkg::OP_BYTE, 64'hFFFF_FFFF_FFFF_FF00, 1'b0);
    add_item(lbp_pkg::OP_BYTE, 64'h0000_0000_0000_00FF, 1'b0);
    add_item(lbp_pkg::OP_INT, 64'h0, 1'b0);
    add_item(lbp_pkg::OP_INT, 64'h1, 1'b0);
    add_item(lbp_pkg::OP_INT, 64'h100, 1'b0);
    add_item(lbp_pkg::OP_BIT, 64'h1, 1'b0);
    // seven bits held plus the widest integer gives ten bytes
    add_item(lbp_pkg::OP_INT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    add_item(lbp_pkg::OP_INT, 64'h80, 1'b0);
    add_item(lbp_pkg::OP_INT, 64'h8000_0000_0000_0000, 1'b0);
    add_item(lbp_pkg::OP_INT, 64'h00FF_FFFF_FFFF_FFFF, 1'b0);
    add_item(lbp_pkg::OP_FLUSH, 64'h0, 1'b0);
    add_item(lbp_pkg::OP_BYTE, 64'h5A5A_5A5A_5A5A_5AA5, 1'b0);
    add_item(lbp_pkg::OP_BIT, 64'h0, 1'b0);
    add_item(lbp_pkg::OP_BYTE, 64'h0, 1'b0);
    add_item(lbp_pkg::OP_FLUSH, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);

    // random: integers of random byte length most often, then bits, bytes and flushes
    for (int k = 0; k < 260; k++) begin
      sel = $urandom_range(99);
      v = {$urandom, $urandom};
      if (sel < 20) begin
        add_item(lbp_pkg::OP_BIT, v, (k == 100) || ($urandom_range(99) < 2));
      end else if (sel < 40) begin
        add_item(lbp_pkg::OP_BYTE, v, (k == 100) || ($urandom_range(99) < 2));
      end else if (sel < 88) begin
        nbytes = $urandom_range(8);
        if (nbytes < 8) v = v & ((64'd1 << (nbytes * 8)) - 64'd1);
        add_item(lbp_pkg::OP_INT, v, (k == 100) || ($urandom_range(99) < 2));
      end else begin
        add_item(lbp_pkg::OP_FLUSH, v, (k == 100) || ($urandom_range(99) < 2));
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_valid) @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    if (mismatch_count == 0 && expected_bytes.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
